@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the thermostat scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, skipped while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// Types and constants of the periodic thermostat scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TASK_COUNT   = 3;
    localparam int TASK_BUTTON  = 0;
    localparam int TASK_SAMPLE  = 1;
    localparam int TASK_REPORT  = 2;

    localparam int TICK_W       = 10;
    localparam int PERIOD_W     = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int SENSOR_W     = 16;
    localparam int TEMP_W       = 9;
    localparam int SETP_W       = 8;
    localparam int SECONDS_W    = 32;
    localparam int OUT_DATA_W   = 56;

    localparam logic [PERIOD_W-1:0] ELAPSED_MAX     = 16'hFFFF;
    localparam logic [TICK_W-1:0]   TICK_MS_RST     = 10'd100;
    localparam logic [PERIOD_W-1:0] BUTTON_P_RST    = 16'd200;
    localparam logic [PERIOD_W-1:0] SAMPLE_P_RST    = 16'd500;
    localparam logic [PERIOD_W-1:0] REPORT_P_RST    = 16'd1000;
    localparam logic signed [SETP_W-1:0] SETP_RST   = 8'sd25;
    localparam logic signed [SETP_W-1:0] SETP_MAX   = 8'sd127;
    localparam logic signed [SETP_W-1:0] SETP_MIN   = -8'sd128;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_UP   = 2'd1,
        KIND_DOWN = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_MS   = 2'd0,
        CFG_BUTTON_P  = 2'd1,
        CFG_SAMPLE_P  = 2'd2,
        CFG_REPORT_P  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic report;
        logic sample;
        logic button;
    } t_due;

    typedef struct packed {
        logic [SECONDS_W-1:0]     seconds;
        logic                     heater_on;
        logic signed [SETP_W-1:0] setpoint;
        logic signed [TEMP_W-1:0] temperature;
    } t_result;

endpackage

@@ hdl/pts_task_timer.sv @@
// ----------------------------------------------------------------------------
// pts_task_timer
// Tick length and task period registers, per-task elapsed counters and due
// flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_task_timer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pts_pkg::t_cfg_wr i_cfg,
    input  logic             i_tick,
    output pts_pkg::t_due    o_due
);

    logic [pts_pkg::TICK_W-1:0]   r_tick_ms;
    logic [pts_pkg::PERIOD_W-1:0] r_period [pts_pkg::TASK_COUNT];
    logic [pts_pkg::PERIOD_W-1:0] r_elapsed [pts_pkg::TASK_COUNT];
    logic [pts_pkg::PERIOD_W-1:0] n_elapsed [pts_pkg::TASK_COUNT];
    logic [pts_pkg::TASK_COUNT-1:0] w_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms                      <= pts_pkg::TICK_MS_RST;
            r_period[pts_pkg::TASK_BUTTON] <= pts_pkg::BUTTON_P_RST;
            r_period[pts_pkg::TASK_SAMPLE] <= pts_pkg::SAMPLE_P_RST;
            r_period[pts_pkg::TASK_REPORT] <= pts_pkg::REPORT_P_RST;
        end else if (i_cfg.en) begin
            unique case (pts_pkg::t_cfg_idx'(i_cfg.index))
                pts_pkg::CFG_TICK_MS:  r_tick_ms <= i_cfg.data[pts_pkg::TICK_W-1:0];
                pts_pkg::CFG_BUTTON_P: r_period[pts_pkg::TASK_BUTTON] <= i_cfg.data;
                pts_pkg::CFG_SAMPLE_P: r_period[pts_pkg::TASK_SAMPLE] <= i_cfg.data;
                pts_pkg::CFG_REPORT_P: r_period[pts_pkg::TASK_REPORT] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [pts_pkg::PERIOD_W:0] sum;
        sum = '0;
        for (int i = 0; i < pts_pkg::TASK_COUNT; i++) begin
            w_due[i] = (r_elapsed[i] >= r_period[i]);
            sum      = {1'b0, r_elapsed[i]}
                     + {{(pts_pkg::PERIOD_W + 1 - pts_pkg::TICK_W){1'b0}}, r_tick_ms};
            if (w_due[i]) begin
                n_elapsed[i] = '0;
            end else if (sum[pts_pkg::PERIOD_W]) begin
                n_elapsed[i] = pts_pkg::ELAPSED_MAX;
            end else begin
                n_elapsed[i] = sum[pts_pkg::PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pts_pkg::TASK_COUNT; i++) begin
                r_elapsed[i] <= pts_pkg::ELAPSED_MAX;
            end
        end else if (i_tick) begin
            for (int i = 0; i < pts_pkg::TASK_COUNT; i++) begin
                r_elapsed[i] <= n_elapsed[i];
            end
        end
    end

    assign o_due.button = w_due[pts_pkg::TASK_BUTTON];
    assign o_due.sample = w_due[pts_pkg::TASK_SAMPLE];
    assign o_due.report = w_due[pts_pkg::TASK_REPORT];

    `ASSERT_CLK(a_report_clears, i_tick && o_due.report |=> r_elapsed[pts_pkg::TASK_REPORT] == '0, "report count not cleared after run")
    `ASSERT_CLK(a_idle_holds, !i_tick && !i_cfg.en |=> $stable(o_due), "due flags moved without tick")

endmodule

@@ hdl/pts_task_core.sv @@
// ----------------------------------------------------------------------------
// pts_task_core
// Button, sample and report tasks: pending flags, setpoint, captured
// temperature, heater level and report count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_task_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [1:0]                    i_kind,
    input  logic [pts_pkg::SENSOR_W-1:0]  i_sensor,
    input  pts_pkg::t_due                 i_due,
    output logic                          o_has_result,
    output pts_pkg::t_result              o_result
);

    logic                                 r_up;
    logic                                 r_down;
    logic signed [pts_pkg::SETP_W-1:0]    r_set_temp;
    logic signed [pts_pkg::TEMP_W-1:0]    r_cap_temp;
    logic                                 r_heater;
    logic [pts_pkg::SECONDS_W-1:0]        r_count;

    logic                                 n_up;
    logic                                 n_down;
    logic signed [pts_pkg::SETP_W-1:0]    n_set_temp;
    logic signed [pts_pkg::TEMP_W-1:0]    n_cap_temp;
    logic                                 n_heater;
    logic [pts_pkg::SECONDS_W-1:0]        n_count;

    logic signed [pts_pkg::SENSOR_W:0]    w_sum;
    logic signed [pts_pkg::TEMP_W-1:0]    w_sample;

    // truncate toward zero: bias negative words before the arithmetic shift
    assign w_sum    = $signed({i_sensor[pts_pkg::SENSOR_W-1], i_sensor})
                    + (i_sensor[pts_pkg::SENSOR_W-1] ? 17'sd127 : 17'sd0);
    assign w_sample = w_sum[pts_pkg::SENSOR_W-1:pts_pkg::SENSOR_W-pts_pkg::TEMP_W];

    always_comb begin
        logic signed [pts_pkg::SETP_W-1:0] sp;
        logic signed [pts_pkg::TEMP_W-1:0] sp_ext;
        n_up         = r_up;
        n_down       = r_down;
        n_set_temp   = r_set_temp;
        n_cap_temp   = r_cap_temp;
        n_heater     = r_heater;
        n_count      = r_count;
        o_has_result = 1'b0;
        sp           = r_set_temp;
        sp_ext       = '0;
        if (i_fire) begin
            case (i_kind)
                pts_pkg::KIND_UP:   n_up   = 1'b1;
                pts_pkg::KIND_DOWN: n_down = 1'b1;
                pts_pkg::KIND_TICK: begin
                    if (i_due.button) begin
                        if (r_up && sp != pts_pkg::SETP_MAX) sp = sp + 8'sd1;
                        if (r_down && sp != pts_pkg::SETP_MIN) sp = sp - 8'sd1;
                        n_set_temp = sp;
                        n_up       = 1'b0;
                        n_down     = 1'b0;
                    end
                    if (i_due.sample) begin
                        n_cap_temp = w_sample;
                    end
                    if (i_due.report) begin
                        sp_ext       = {n_set_temp[pts_pkg::SETP_W-1], n_set_temp};
                        n_heater     = (n_cap_temp >= sp_ext) ? 1'b0 : 1'b1;
                        n_count      = r_count + 32'd1;
                        o_has_result = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up       <= 1'b0;
            r_down     <= 1'b0;
            r_set_temp <= pts_pkg::SETP_RST;
            r_cap_temp <= '0;
            r_heater   <= 1'b0;
            r_count    <= '0;
        end else begin
            r_up       <= n_up;
            r_down     <= n_down;
            r_set_temp <= n_set_temp;
            r_cap_temp <= n_cap_temp;
            r_heater   <= n_heater;
            r_count    <= n_count;
        end
    end

    assign o_result.temperature = n_cap_temp;
    assign o_result.setpoint    = n_set_temp;
    assign o_result.heater_on   = n_heater;
    assign o_result.seconds     = r_count;

    `ASSERT_CLK(a_count_step, o_has_result |=> r_count == $past(r_count) + 32'd1, "report count did not advance")
    `ASSERT_CLK(a_setp_hold, !(i_fire && i_kind == pts_pkg::KIND_TICK && i_due.button) |=> $stable(r_set_temp), "setpoint moved outside button task")
    `ASSERT_ALWAYS(a_result_fire, o_has_result |-> i_fire && i_due.report, "result without report run")

endmodule

@@ hdl/periodic_thermostat_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// periodic_thermostat_scheduler_unit
// On-off thermostat run by three periodic tasks (button, sample, report).
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tuser kind, tdata sensor word
//   m_axis    out  tvalid/tready           tdata report result
//   cfg       in   i_cfg_valid/o_cfg_ready register index and value
//
// One beat enters per cycle while the result side keeps up; a result passes
// from its input beat through the input register, then the result register.
// The task logic sits between the two registers; only a full result
// register that is not taken holds the input side.
// Synchronous active-low reset restores defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_thermostat_scheduler_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [pts_pkg::SENSOR_W-1:0]     i_s_axis_tdata,  // [15:0] sensor_raw
    input  logic [1:0]                       i_s_axis_tuser,  // [1:0] kind
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [8:0] temperature, [16:9] setpoint, [17] heater_on, [49:18] seconds, zero above
    output logic [pts_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int RES_W = $bits(pts_pkg::t_result);

    logic                             r_in_valid;
    logic [1:0]                       r_in_kind;
    logic [pts_pkg::SENSOR_W-1:0]     r_in_sensor;
    logic                             r_out_valid;
    pts_pkg::t_result                 r_out_data;

    logic                             w_advance;
    logic                             w_tick;
    logic                             w_has_result;
    pts_pkg::t_result                 w_result;
    pts_pkg::t_due                    w_due;
    pts_pkg::t_cfg_wr                 w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.en    = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_tick          = w_advance && (r_in_kind == pts_pkg::KIND_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_kind   <= i_s_axis_tuser;
            r_in_sensor <= i_s_axis_tdata;
        end
    end

    pts_task_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_tick  (w_tick),
        .o_due   (w_due)
    );

    pts_task_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_advance),
        .i_kind       (r_in_kind),
        .i_sensor     (r_in_sensor),
        .i_due        (w_due),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(pts_pkg::OUT_DATA_W - RES_W){1'b0}}, r_out_data};

    `ASSERT_CLK(a_no_overrun, w_advance |-> !(r_out_valid && !i_m_axis_tready), "beat advanced into a stalled result")

endmodule

@@ tb/sv/thermostat_report_checker.sv @@
// ----------------------------------------------------------------------------
// thermostat_report_checker
// Watches the input, register and result channels of the thermostat
// scheduler, tracks the task timers and thermostat state, queues the report
// each report-due tick should produce and compares every result beat field by field.
// ----------------------------------------------------------------------------
module thermostat_report_checker
    import pts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [SENSOR_W-1:0]   i_s_tdata,    // [15:0] sensor_raw
    input  logic [1:0]            i_s_tuser,    // [1:0] kind
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [8:0] temperature, [16:9] setpoint, [17] heater_on, [49:18] seconds, zero above
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int RES_W = $bits(t_result);

    logic [TICK_W-1:0]        tick_len;
    logic [PERIOD_W-1:0]      task_period  [TASK_COUNT];
    logic [PERIOD_W-1:0]      task_elapsed [TASK_COUNT];
    logic                     raise_req;
    logic                     lower_req;
    logic signed [SETP_W-1:0] setpoint_q;
    logic signed [TEMP_W-1:0] temp_q;
    logic                     heater_q;
    logic [SECONDS_W-1:0]     report_seq;
    t_result                  pending_reports [$];
    int                       miss_count = 0;

    function automatic void log_miss(string msg);
        miss_count++;
        if (miss_count <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    task automatic advance_schedule(input logic [SENSOR_W-1:0] raw);
        t_due              due;
        logic [PERIOD_W:0] sum;
        int                word;
        t_result           rep;
        for (int t = 0; t < TASK_COUNT; t++) begin
            sum    = task_elapsed[t] + tick_len;
            due[t] = task_elapsed[t] >= task_period[t];
            if (due[t])
                task_elapsed[t] = '0;
            else
                task_elapsed[t] = sum[PERIOD_W] ? ELAPSED_MAX : sum[PERIOD_W-1:0];
        end
        if (due.button) begin
            if (raise_req && setpoint_q != SETP_MAX)
                setpoint_q = setpoint_q + 8'sd1;
            if (lower_req && setpoint_q != SETP_MIN)
                setpoint_q = setpoint_q - 8'sd1;
            raise_req = 1'b0;
            lower_req = 1'b0;
        end
        if (due.sample) begin
            word   = $signed(raw);
            temp_q = TEMP_W'(word / 128);
        end
        if (due.report) begin
            heater_q          = (temp_q >= setpoint_q) ? 1'b0 : 1'b1;
            rep.temperature   = temp_q;
            rep.setpoint      = setpoint_q;
            rep.heater_on     = heater_q;
            rep.seconds       = report_seq;
            pending_reports.push_back(rep);
            report_seq++;
        end
    endtask

    task automatic check_report();
        t_result got;
        t_result want;
        got = t_result'(i_m_tdata[RES_W-1:0]);
        if (pending_reports.size() == 0) begin
            log_miss($sformatf("result with none expected, seconds %0d", got.seconds));
        end else begin
            want = pending_reports.pop_front();
            if (got.temperature !== want.temperature)
                log_miss($sformatf("temperature expected %0d got %0d",
                                   want.temperature, got.temperature));
            if (got.setpoint !== want.setpoint)
                log_miss($sformatf("setpoint expected %0d got %0d",
                                   want.setpoint, got.setpoint));
            if (got.heater_on !== want.heater_on)
                log_miss($sformatf("heater_on expected %0d got %0d",
                                   want.heater_on, got.heater_on));
            if (got.seconds !== want.seconds)
                log_miss($sformatf("seconds expected %0d got %0d",
                                   want.seconds, got.seconds));
            if (i_m_tdata[OUT_DATA_W-1:RES_W] !== '0)
                log_miss($sformatf("padding expected 0 got %h",
                                   i_m_tdata[OUT_DATA_W-1:RES_W]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_len                 = TICK_MS_RST;
            task_period[TASK_BUTTON] = BUTTON_P_RST;
            task_period[TASK_SAMPLE] = SAMPLE_P_RST;
            task_period[TASK_REPORT] = REPORT_P_RST;
            foreach (task_elapsed[t])
                task_elapsed[t] = ELAPSED_MAX;
            raise_req  = 1'b0;
            lower_req  = 1'b0;
            setpoint_q = SETP_RST;
            temp_q     = '0;
            heater_q   = 1'b0;
            report_seq = '0;
            pending_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TICK_MS:  tick_len                 = i_cfg_data[TICK_W-1:0];
                    CFG_BUTTON_P: task_period[TASK_BUTTON] = i_cfg_data;
                    CFG_SAMPLE_P: task_period[TASK_SAMPLE] = i_cfg_data;
                    CFG_REPORT_P: task_period[TASK_REPORT] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    KIND_TICK: advance_schedule(i_s_tdata);
                    KIND_UP:   raise_req = 1'b1;
                    KIND_DOWN: lower_req = 1'b1;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready)
                check_report();
        end
        o_pending    <= pending_reports.size();
        o_fail_count <= miss_count;
    end

endmodule

@@ tb/sv/periodic_thermostat_scheduler_unit_test.sv @@
// ----------------------------------------------------------------------------
// periodic_thermostat_scheduler_unit_test
// Drives ticks, setpoint presses and ignored beats into the thermostat
// scheduler across several register settings and idle patterns, with a
// short directed opening and long random runs biased to push the setpoint
// into both limits; the checker instance predicts and scores the reports.
// ----------------------------------------------------------------------------
module periodic_thermostat_scheduler_unit_test;
    import pts_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         LIMIT_CYCLES  = 250000;

    localparam logic [17:0] OPENING [12] = '{
        {KIND_TICK, 16'h0C80}, {KIND_UP, 16'h1234}, {KIND_DOWN, 16'hFFFF},
        {KIND_UNUSED, 16'h7FFF}, {KIND_TICK, 16'h0000}, {KIND_UP, 16'h0000},
        {KIND_UP, 16'h0000}, {KIND_TICK, 16'h8000}, {KIND_TICK, 16'h4000},
        {KIND_UNUSED, 16'h0000}, {KIND_TICK, 16'hFFFF}, {KIND_TICK, 16'h1900}
    };
    localparam logic [17:0] EDGE_RUN [13] = '{
        {KIND_TICK, 16'h7FFF}, {KIND_TICK, 16'h8000}, {KIND_TICK, 16'hFF81},
        {KIND_TICK, 16'hFF80}, {KIND_TICK, 16'h0080}, {KIND_TICK, 16'h007F},
        {KIND_UP, 16'hAAAA}, {KIND_DOWN, 16'h5555}, {KIND_TICK, 16'h0C80},
        {KIND_UP, 16'h0000}, {KIND_TICK, 16'h0000}, {KIND_UNUSED, 16'hFFFF},
        {KIND_TICK, 16'hFFFF}
    };
    localparam logic [15:0] SENSOR_EDGES [8] = '{
        16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0080, 16'hFF80, 16'hFF81, 16'h007F
    };

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [SENSOR_W-1:0]   s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cfg_ready;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;

    periodic_thermostat_scheduler_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    thermostat_report_checker report_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic push_beat(input logic [1:0] kind, input logic [SENSOR_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= raw;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] tick_word, bp, sp, rp);
        t_cfg_idx              slot [4];
        logic [CFG_DATA_W-1:0] word [4];
        slot = '{CFG_TICK_MS, CFG_BUTTON_P, CFG_SAMPLE_P, CFG_REPORT_P};
        word = '{tick_word, bp, sp, rp};
        foreach (slot[r]) begin
            cfg_valid <= 1'b1;
            cfg_index <= slot[r];
            cfg_data  <= word[r];
            do @(posedge i_clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly press-then-tick pairs; up_pct leans the presses one way
    task automatic run_phase(input int count, input int up_pct);
        logic [1:0]          kind;
        logic [SENSOR_W-1:0] raw;
        logic                after_press;
        int                  roll;
        after_press = 1'b0;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 3)
                kind = KIND_UNUSED;
            else if (roll < (after_press ? 78 : 38))
                kind = KIND_TICK;
            else
                kind = ($urandom_range(99) < up_pct) ? KIND_UP : KIND_DOWN;
            after_press = (kind == KIND_UP) || (kind == KIND_DOWN);
            if ($urandom_range(99) < 20)
                raw = SENSOR_EDGES[$urandom_range(7)];
            else
                raw = 16'($urandom);
            push_beat(kind, raw);
        end
    endtask

    initial begin
        logic [TICK_W-1:0]     tick_val;
        logic [CFG_DATA_W-1:0] per [3];
        int                    roll;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING[i])
            push_beat(OPENING[i][17:16], OPENING[i][15:0]);
        wait_drained();
        program_regs(16'd1, 16'd0, 16'd0, 16'd0);
        foreach (EDGE_RUN[i])
            push_beat(EDGE_RUN[i][17:16], EDGE_RUN[i][15:0]);

        // drive the setpoint up into its ceiling
        wait_drained();
        run_phase(280, 95);

        wait_drained();
        program_regs(16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 57;
        run_phase(150, 50);

        wait_drained();
        program_regs(16'd0, 16'd0, 16'd300, 16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        run_phase(150, 5);

        // then down into its floor
        wait_drained();
        program_regs(16'd7, 16'd0, 16'd0, 16'd3);
        run_phase(450, 5);

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        repeat (5) begin
            wait_drained();
            tick_val = 10'($urandom_range(1, 1000));
            foreach (per[t]) begin
                roll = $urandom_range(99);
                if (roll < 15)
                    per[t] = '0;
                else if (roll < 25)
                    per[t] = 16'($urandom);
                else
                    per[t] = 16'($urandom_range(0, 6 * tick_val));
            end
            program_regs({6'($urandom_range(63)), tick_val}, per[0], per[1], per[2]);
            run_phase(100, 50);
        end

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 4);
        $display("FAIL");
        $finish;
    end

endmodule
